// File: sv/graph_encoder_embedding_accumulator_defines.svh
// Assertion macros for the graph encoder embedding accumulator.
// Depends on nothing; the asserting module supplies clk_i and rst_ni.
`ifndef GRAPH_ENCODER_EMBEDDING_ACCUMULATOR_DEFINES_SVH
`define GRAPH_ENCODER_EMBEDDING_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GEACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GEACC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GEACC_ASSERT(lbl, prop, msg)
`define GEACC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: sv/geacc_pkg.sv
// Shared codes and types of the graph encoder embedding accumulator.
// Depends on nothing.
package geacc_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_VERTEX = 2'd1;
  localparam logic [1:0] ST_LABEL  = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_LABEL_COUNT  = 1'b1;

  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quotient;
  } div_rsp_t;

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_LAB_A   = 16'h0004,
    S_LAB_B   = 16'h0008,
    S_CHECK   = 16'h0010,
    S_CNT_RD0 = 16'h0020,
    S_CNT_WR0 = 16'h0040,
    S_CNT_RD1 = 16'h0080,
    S_CNT_WR1 = 16'h0100,
    S_ACC_CNT = 16'h0200,
    S_DIV_GO  = 16'h0400,
    S_ACC_DIV = 16'h0800,
    S_ACC_RD  = 16'h1000,
    S_ACC_WR  = 16'h2000,
    S_RD_EMB  = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

endpackage

// File: sv/geacc_ram.sv
// Generic simple dual port RAM with registered read.
// Depends on nothing.
module geacc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/geacc_div.sv
// Restoring divider, one quotient bit per cycle, 17 quotient bits per division.
// Depends on geacc_pkg.
module geacc_div
  import geacc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [8:0]  rem_q;
  logic [8:0]  dvs_q;
  logic [16:0] quo_q;
  logic [9:0]  trial;
  logic        fits;

  assign trial = {rem_q, quo_q[16]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd16) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= fits ? 9'(trial - {1'b0, dvs_q}) : trial[8:0];
      quo_q <= {quo_q[15:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: sv/graph_encoder_embedding_accumulator.sv
// Graph encoder embedding accumulator: label store, label counts, embedding store.
// Items run to completion before the next is taken; a relabel also decrements the old
// label count. An edge updates one endpoint on a self loop else two, each by a divider
// wait and embedding RMW. Output is valid on return to idle; a stalled result holds the
// input stalled. Reset clears one entry a cycle over MAX_VERTICES*MAX_LABELS entries
// (16384 at defaults, capped at 256 x 64) before taking input. Uses geacc_pkg, geacc_ram, geacc_div.
`include "graph_encoder_embedding_accumulator_defines.svh"
module graph_encoder_embedding_accumulator
  import geacc_pkg::*;
#(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_LABELS   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_opcode_i,
  input  logic [7:0]         in_vertex_a_i,
  input  logic [7:0]         in_vertex_b_i,
  input  logic [5:0]         in_class_label_i,
  input  logic signed [15:0] in_edge_weight_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_status_o,
  output logic signed [31:0] out_entry_value_o,
  output logic               out_saturated_o
);

  localparam int VDEPTH = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam int LDEPTH = (MAX_LABELS < 64) ? MAX_LABELS : 64;
  localparam int EDEPTH = VDEPTH * LDEPTH;
  localparam int VAW = $clog2(VDEPTH);
  localparam int LAW = $clog2(LDEPTH);
  localparam int EAW = $clog2(EDEPTH);
  localparam logic [5:0] LMASK = 6'(MAX_LABELS - 1);

  state_e state_q, state_d;

  logic [8:0] vcnt_q;
  logic [6:0] lcnt_q;
  logic [EAW-1:0] clr_q;
  logic [1:0] op_q;
  logic [7:0] va_q, vb_q;
  logic [5:0] lab_q;
  logic signed [15:0] w_q;
  logic [6:0] lwa_q, lwb_q;
  logic pass_q;
  logic signed [17:0] inc_q;
  logic [1:0] status_q;
  logic [31:0] value_q;
  logic sat_q;
  logic out_valid_q;
  logic [1:0] out_status_q;
  logic [31:0] out_value_q;
  logic out_sat_q;

  logic lab_we, cnt_we, emb_we;
  logic [VAW-1:0] lab_waddr, lab_raddr;
  logic [6:0] lab_wdata, lab_rdata;
  logic [LAW-1:0] cnt_waddr, cnt_raddr;
  logic [8:0] cnt_wdata, cnt_rdata;
  logic [EAW-1:0] emb_waddr, emb_raddr;
  logic [31:0] emb_wdata, emb_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept;
  logic va_ok, vb_ok, lab_ok, la_ok, lb_ok;
  logic [5:0] la, lb, old_lab, acc_col;
  logic [7:0] acc_row;
  logic [EAW-1:0] acc_addr, rd_addr;
  logic signed [32:0] sum;
  logic [16:0] wmag;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign la      = lwa_q[5:0];
  assign lb      = lab_rdata[5:0];
  assign old_lab = lwa_q[5:0] & LMASK;
  assign va_ok   = ({1'b0, va_q} < vcnt_q) && (int'(va_q) < MAX_VERTICES);
  assign vb_ok   = ({1'b0, vb_q} < vcnt_q) && (int'(vb_q) < MAX_VERTICES);
  assign lab_ok  = ({1'b0, lab_q} < lcnt_q) && (int'(lab_q) < MAX_LABELS);
  assign la_ok   = ({1'b0, la} < lcnt_q) && (int'(la) < MAX_LABELS);
  assign lb_ok   = ({1'b0, lb} < lcnt_q) && (int'(lb) < MAX_LABELS);

  assign acc_row  = pass_q ? vb_q : va_q;
  assign acc_col  = pass_q ? lwa_q[5:0] : lwb_q[5:0];
  assign acc_addr = EAW'(int'(acc_row) * LDEPTH + int'(acc_col));
  assign rd_addr  = EAW'(int'(va_q) * LDEPTH + int'(lab_q));
  assign sum      = {emb_rdata[31], emb_rdata} + 33'(inc_q);
  assign wmag     = w_q[15] ? 17'(-{w_q[15], w_q}) : {1'b0, w_q};

  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = va_q[VAW-1:0];
    lab_wdata = {1'b1, lab_q};
    lab_raddr = (state_q == S_LAB_B) ? vb_q[VAW-1:0] : va_q[VAW-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = lab_q[LAW-1:0];
    cnt_wdata = 9'(cnt_rdata + 9'd1);
    cnt_raddr = lab_q[LAW-1:0];
    emb_we    = 1'b0;
    emb_waddr = acc_addr;
    emb_wdata = sum[31:0];
    emb_raddr = (state_q == S_RD_EMB || state_q == S_DONE) ? rd_addr : acc_addr;
    div_req.start    = (state_q == S_DIV_GO);
    div_req.dividend = wmag;
    div_req.divisor  = (cnt_rdata == 9'd0) ? 9'd1 : cnt_rdata;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        emb_we    = 1'b1;
        emb_waddr = clr_q;
        emb_wdata = '0;
        lab_we    = int'(clr_q) < VDEPTH;
        lab_waddr = clr_q[VAW-1:0];
        lab_wdata = '0;
        cnt_we    = int'(clr_q) < LDEPTH;
        cnt_waddr = clr_q[LAW-1:0];
        cnt_wdata = '0;
        if (clr_q == EAW'(EDEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: if (accept) state_d = S_LAB_A;
      S_LAB_A: state_d = S_LAB_B;
      S_LAB_B: state_d = S_CHECK;
      S_CHECK: begin
        case (op_q)
          OP_LOAD: begin
            if (!va_ok || !lab_ok) state_d = S_DONE;
            else if (lwa_q[6]) state_d = S_CNT_RD0;
            else state_d = S_CNT_RD1;
          end
          OP_EDGE: begin
            if (!va_ok || !vb_ok || !lwa_q[6] || !lab_rdata[6] || !la_ok || !lb_ok) begin
              state_d = S_DONE;
            end else begin
              state_d = S_ACC_CNT;
            end
          end
          OP_READ: begin
            if (!va_ok || !lab_ok) state_d = S_DONE;
            else state_d = S_RD_EMB;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_CNT_RD0: begin
        cnt_raddr = old_lab[LAW-1:0];
        state_d   = S_CNT_WR0;
      end
      S_CNT_WR0: begin
        cnt_we    = cnt_rdata != 9'd0;
        cnt_waddr = old_lab[LAW-1:0];
        cnt_wdata = 9'(cnt_rdata - 9'd1);
        state_d   = S_CNT_RD1;
      end
      S_CNT_RD1: state_d = S_CNT_WR1;
      S_CNT_WR1: begin
        cnt_we  = 1'b1;
        lab_we  = 1'b1;
        state_d = S_DONE;
      end
      S_ACC_CNT: begin
        cnt_raddr = acc_col[LAW-1:0];
        state_d   = S_DIV_GO;
      end
      S_DIV_GO: state_d = S_ACC_DIV;
      S_ACC_DIV: if (div_rsp.done) state_d = S_ACC_RD;
      S_ACC_RD: state_d = S_ACC_WR;
      S_ACC_WR: begin
        emb_we = 1'b1;
        if (sum > 33'sd2147483647) emb_wdata = 32'h7fff_ffff;
        else if (sum < -33'sd2147483648) emb_wdata = 32'h8000_0000;
        if (!pass_q && va_q != vb_q) state_d = S_ACC_CNT;
        else state_d = S_DONE;
      end
      S_RD_EMB: state_d = S_DONE;
      S_DONE: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      vcnt_q      <= 9'd256;
      lcnt_q      <= 7'd64;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + EAW'(1);
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_VERTEX_COUNT) vcnt_q <= cfg_data_i;
        if (cfg_index_i == CFG_LABEL_COUNT) lcnt_q <= cfg_data_i[6:0];
      end
      if (state_q == S_DONE && state_d == S_IDLE) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_opcode_i;
      va_q     <= in_vertex_a_i;
      vb_q     <= in_vertex_b_i;
      lab_q    <= in_class_label_i;
      w_q      <= in_edge_weight_i;
      pass_q   <= 1'b0;
      status_q <= ST_OK;
      value_q  <= '0;
      sat_q    <= 1'b0;
    end
    if (state_q == S_LAB_B) lwa_q <= lab_rdata;
    if (state_q == S_CHECK) begin
      lwb_q <= lab_rdata;
      case (op_q)
        OP_LOAD, OP_READ: begin
          if (!va_ok) status_q <= ST_VERTEX;
          else if (!lab_ok) status_q <= ST_LABEL;
        end
        OP_EDGE: begin
          if (!va_ok || !vb_ok) status_q <= ST_VERTEX;
          else if (!lwa_q[6] || !lab_rdata[6] || !la_ok || !lb_ok) status_q <= ST_LABEL;
        end
        default: status_q <= ST_OK;
      endcase
    end
    if (state_q == S_ACC_DIV && div_rsp.done) begin
      inc_q <= w_q[15] ? -$signed({1'b0, div_rsp.quotient}) : $signed({1'b0, div_rsp.quotient});
    end
    if (state_q == S_ACC_WR) begin
      pass_q <= 1'b1;
      if (sum > 33'sd2147483647 || sum < -33'sd2147483648) sat_q <= 1'b1;
    end
    if (state_q == S_DONE && op_q == OP_READ && status_q == ST_OK) value_q <= emb_rdata;
    if (state_q == S_DONE && state_d == S_IDLE) begin
      out_status_q <= status_q;
      out_value_q  <= (op_q == OP_READ && status_q == ST_OK) ? emb_rdata : value_q;
      out_sat_q    <= sat_q;
    end
  end

  geacc_ram #(.WIDTH(7), .DEPTH(VDEPTH)) u_lab_ram (
    .clk_i, .we_i(lab_we), .waddr_i(lab_waddr), .wdata_i(lab_wdata),
    .raddr_i(lab_raddr), .rdata_o(lab_rdata)
  );

  geacc_ram #(.WIDTH(9), .DEPTH(LDEPTH)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  geacc_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_emb_ram (
    .clk_i, .we_i(emb_we), .waddr_i(emb_waddr), .wdata_i(emb_wdata),
    .raddr_i(emb_raddr), .rdata_o(emb_rdata)
  );

  geacc_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_entry_value_o = out_value_q;
  assign out_saturated_o   = out_sat_q;

  `GEACC_ASSERT(a_div_done_in_wait, div_rsp.done |-> state_q == S_ACC_DIV, "divider done out of turn")
  `GEACC_ASSERT(a_accept_starts, accept |=> state_q == S_LAB_A, "accepted beat did not start")
  `GEACC_ASSERT(a_emb_write_owner, emb_we |-> (state_q == S_ACC_WR || state_q == S_CLEAR), "stray embedding write")
  `GEACC_ASSERT_RST(a_reset_clears, !rst_ni |=> !out_valid_o, "output valid across reset")

endmodule

// File: test/graph_encoder_embedding_accumulator_tb.sv
// Self-checking testbench for the graph encoder embedding accumulator.
// Predicts labels, counts and embedding entries per beat and compares each result.
// Depends on geacc_pkg and graph_encoder_embedding_accumulator.
`timescale 1ns / 100ps
module graph_encoder_embedding_accumulator_tb
  import geacc_pkg::*;
;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               sat;
  } emb_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [8:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] in_opcode_i = '0;
  logic [7:0] in_vertex_a_i = '0;
  logic [7:0] in_vertex_b_i = '0;
  logic [5:0] in_class_label_i = '0;
  logic signed [15:0] in_edge_weight_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] out_status_o;
  logic signed [31:0] out_entry_value_o;
  logic out_saturated_o;

  graph_encoder_embedding_accumulator dut (.*);

  int unsigned vcount;
  int unsigned lcount;
  bit          has_label [256];
  logic [5:0]  vlabel [256];
  int unsigned lab_tally [64];
  logic signed [31:0] emb [16384];
  emb_result_t pending_results [$];
  int errors = 0;
  longint cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic bit v_in(int unsigned v);
    return v < vcount && v < 256;
  endfunction

  function automatic bit l_in(int unsigned l);
    return l < lcount && l < 64;
  endfunction

  function automatic bit add_entry(int unsigned row, int unsigned col, logic signed [15:0] w);
    int unsigned cnt;
    longint inc;
    longint sum;
    cnt = lab_tally[col] == 0 ? 1 : lab_tally[col];
    inc = longint'(w) / longint'(cnt);
    sum = longint'(emb[row*64+col]) + inc;
    if (sum > 64'sd2147483647) begin
      emb[row*64+col] = 32'sh7fffffff;
      return 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      emb[row*64+col] = 32'sh80000000;
      return 1'b1;
    end
    emb[row*64+col] = 32'(sum);
    return 1'b0;
  endfunction

  function automatic emb_result_t predict_embedding(logic [1:0] op, logic [7:0] va,
      logic [7:0] vb, logic [5:0] lab, logic signed [15:0] w);
    emb_result_t r;
    r = '{status: ST_OK, value: '0, sat: 1'b0};
    if (op == OP_LOAD) begin
      if (!v_in(va)) r.status = ST_VERTEX;
      else if (!l_in(lab)) r.status = ST_LABEL;
      else begin
        if (has_label[va] && lab_tally[vlabel[va]] > 0) lab_tally[vlabel[va]]--;
        has_label[va] = 1'b1;
        vlabel[va] = lab;
        lab_tally[lab]++;
      end
    end else if (op == OP_EDGE) begin
      if (!v_in(va) || !v_in(vb)) r.status = ST_VERTEX;
      else if (!has_label[va] || !has_label[vb] || !l_in(vlabel[va]) || !l_in(vlabel[vb]))
        r.status = ST_LABEL;
      else begin
        if (add_entry(va, vlabel[vb], w)) r.sat = 1'b1;
        if (va != vb && add_entry(vb, vlabel[va], w)) r.sat = 1'b1;
      end
    end else if (op == OP_READ) begin
      if (!v_in(va)) r.status = ST_VERTEX;
      else if (!l_in(lab)) r.status = ST_LABEL;
      else r.value = emb[va*64+lab];
    end
    return r;
  endfunction

  task automatic send_beat(logic [1:0] op, logic [7:0] va, logic [7:0] vb,
      logic [5:0] lab, logic signed [15:0] w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    repeat (gap + 1) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_opcode_i <= op;
    in_vertex_a_i <= va;
    in_vertex_b_i <= vb;
    in_class_label_i <= lab;
    in_edge_weight_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_embedding(op, va, vb, lab, w));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    emb_result_t exp_r;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat");
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status_o !== exp_r.status || out_entry_value_o !== exp_r.value ||
            out_saturated_o !== exp_r.sat) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d val=%0d sat=%0d got st=%0d val=%0d sat=%0d",
                     exp_r.status, exp_r.value, exp_r.sat,
                     out_status_o, out_entry_value_o, out_saturated_o);
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (n > 0) n--;
      else begin
        out_stall_i <= ($urandom_range(0, 2) == 0) ? 1'b1 : 1'b0;
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      end
    end
  end

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 9'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VERTEX_COUNT) vcount = val & 9'h1ff;
    else lcount = val & 7'h7f;
  endtask

  task automatic test_directed();
    send_beat(OP_LOAD, 8'd0, 8'd0, 6'd0, 16'sd0);
    send_beat(OP_LOAD, 8'd255, 8'd0, 6'd63, 16'sd0);
    send_beat(OP_LOAD, 8'd1, 8'd0, 6'd0, 16'sd0);
    send_beat(OP_EDGE, 8'd0, 8'd255, 6'd0, 16'sh7fff);
    send_beat(OP_EDGE, 8'd1, 8'd255, 6'd0, -16'sd32768);
    send_beat(OP_EDGE, 8'd0, 8'd0, 6'd0, 16'sd4096);
    send_beat(OP_EDGE, 8'd0, 8'd7, 6'd0, 16'sd4096);
    send_beat(OP_READ, 8'd0, 8'd0, 6'd63, 16'sd0);
    send_beat(OP_READ, 8'd255, 8'd0, 6'd0, 16'sd0);
    send_beat(OP_READ, 8'd7, 8'd0, 6'd5, 16'sd0);
    send_beat(OP_LOAD, 8'd1, 8'd0, 6'd63, 16'sd0);
    send_beat(2'd3, 8'hff, 8'hff, 6'h3f, -16'sd1);
    send_beat(OP_READ, 8'd0, 8'd0, 6'd0, 16'sd0);
    write_reg(CFG_LABEL_COUNT, 1);
    send_beat(OP_EDGE, 8'd0, 8'd255, 6'd0, 16'sd100);
    send_beat(OP_LOAD, 8'd3, 8'd0, 6'd1, 16'sd0);
    write_reg(CFG_VERTEX_COUNT, 0);
    send_beat(OP_READ, 8'd0, 8'd0, 6'd0, 16'sd0);
    write_reg(CFG_LABEL_COUNT, 0);
    write_reg(CFG_VERTEX_COUNT, 2);
    send_beat(OP_LOAD, 8'd1, 8'd0, 6'd0, 16'sd0);
    send_beat(OP_READ, 8'd2, 8'd0, 6'd0, 16'sd0);
  endtask

  task automatic test_saturation();
    write_reg(CFG_VERTEX_COUNT, 256);
    write_reg(CFG_LABEL_COUNT, 64);
    send_beat(OP_LOAD, 8'd10, 8'd0, 6'd20, 16'sd0);
    repeat (18) send_beat(OP_EDGE, 8'd10, 8'd10, 6'd0, 16'sh7fff);
    send_beat(OP_READ, 8'd10, 8'd0, 6'd20, 16'sd0);
  endtask

  task automatic test_random(int unsigned vmax, int unsigned lmax, int items);
    int k;
    logic [1:0] op;
    for (k = 0; k < items; k++) begin
      k = k;
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_LOAD;
        3, 4, 5, 6: op = OP_EDGE;
        7, 8: op = OP_READ;
        default: op = 2'($urandom);
      endcase
      if ($urandom_range(0, 9) == 0)
        send_beat(op, 8'($urandom), 8'($urandom), 6'($urandom), 16'($urandom));
      else
        send_beat(op, 8'($urandom_range(0, vmax)), 8'($urandom_range(0, vmax)),
                  6'($urandom_range(0, lmax)), 16'($urandom));
    end
  endtask

  initial begin
    vcount = 256;
    lcount = 64;
    foreach (lab_tally[i]) lab_tally[i] = 0;
    foreach (has_label[i]) has_label[i] = 1'b0;
    foreach (vlabel[i]) vlabel[i] = '0;
    foreach (emb[i]) emb[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_saturation();
    test_random(15, 7, 300);
    write_reg(CFG_VERTEX_COUNT, 12);
    write_reg(CFG_LABEL_COUNT, 5);
    test_random(15, 7, 250);
    write_reg(CFG_VERTEX_COUNT, 256);
    write_reg(CFG_LABEL_COUNT, 64);
    test_random(255, 63, 250);
    write_reg(CFG_VERTEX_COUNT, 511);
    write_reg(CFG_LABEL_COUNT, 127);
    test_random(40, 10, 120);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: graph_encoder_embedding_accumulator.f
+incdir+sv
sv/geacc_pkg.sv
sv/geacc_ram.sv
sv/geacc_div.sv
sv/graph_encoder_embedding_accumulator.sv
test/graph_encoder_embedding_accumulator_tb.sv
